// ----- sv/assert_macros.svh -----
// assertion macros used by the top-level rtl file
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/brfb_pkg.sv -----
// shared types and constants of the byte ring fifo
// no dependencies
package brfb_pkg;

  localparam int unsigned DEPTH_DEF     = 1024;
  localparam int unsigned MAX_BURST_DEF = 8;

  localparam int unsigned REQ_W  = 2;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned LANE_W = 3;

  localparam int unsigned S_TDATA_W = 72;
  localparam int unsigned M_TDATA_W = 96;

  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic we;        // write one byte to the store
    logic use_rptr;  // store address from the read pointer
    logic cap;       // capture the byte read in the previous cycle
    logic cnt_inc;
    logic wptr_adv;
    logic rptr_adv;
    logic ptr_clr;
    logic set_acc;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic wr_ok;
    logic rd_ok;
    logic is_clear;
    logic last;
    logic out_free;
  } status_t;

endpackage

// ----- sv/brfb_ctrl.sv -----
// control state machine of the byte ring fifo
// depends on brfb_pkg
module brfb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  brfb_pkg::status_t sts_i,
  output brfb_pkg::cmd_t   cmd_o
);
  import brfb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_WRITE,
    S_READ,
    S_READ_LAST,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.wr_ok) begin
          cmd_o.set_acc = 1'b1;
          state_d       = S_WRITE;
        end else if (sts_i.rd_ok) begin
          cmd_o.set_acc = 1'b1;
          state_d       = S_READ;
        end else begin
          cmd_o.ptr_clr = sts_i.is_clear;
          state_d       = S_FINISH;
        end
      end
      S_WRITE: begin
        cmd_o.we      = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.last) begin
          cmd_o.wptr_adv = 1'b1;
          state_d        = S_FINISH;
        end
      end
      S_READ: begin
        // address for the current byte, data of the previous one arrives
        cmd_o.use_rptr = 1'b1;
        cmd_o.cap      = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        if (sts_i.last) begin
          state_d = S_READ_LAST;
        end
      end
      S_READ_LAST: begin
        cmd_o.use_rptr = 1'b1;
        cmd_o.cap      = 1'b1;
        cmd_o.rptr_adv = 1'b1;
        state_d        = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/brfb_dp.sv -----
// datapath of the byte ring fifo: pointers, byte store, result register
// depends on brfb_pkg
module brfb_dp #(
  parameter int unsigned DEPTH     = brfb_pkg::DEPTH_DEF,
  parameter int unsigned MAX_BURST = brfb_pkg::MAX_BURST_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [brfb_pkg::REQ_W-1:0]     req_i,
  input  logic [brfb_pkg::LEN_W-1:0]     len_i,
  input  logic [brfb_pkg::DATA_W-1:0]    wdata_i,
  input  brfb_pkg::cmd_t                 cmd_i,
  output brfb_pkg::status_t              sts_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [brfb_pkg::LEN_W-1:0]     out_acc_o,
  output logic [brfb_pkg::DATA_W-1:0]    out_rdata_o,
  output logic [brfb_pkg::CNT_W-1:0]     out_used_o,
  output logic [brfb_pkg::CNT_W-1:0]     out_free_o
);
  import brfb_pkg::*;

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PTR_W = AW + 1;
  localparam int unsigned CW    = (PTR_W > LEN_W) ? PTR_W : LEN_W;

  logic [REQ_W-1:0]  req_q;
  logic [LEN_W-1:0]  len_q;
  logic [DATA_W-1:0] wdata_q;
  logic [DATA_W-1:0] rdata_q;
  logic [LEN_W-1:0]  cnt_q;
  logic              acc_q;
  logic [PTR_W-1:0]  wptr_q, rptr_q;
  logic [7:0]        mem_q [DEPTH];
  logic [7:0]        rd_q;

  logic              valid_q;
  logic [LEN_W-1:0]  res_acc_q;
  logic [DATA_W-1:0] res_rdata_q;
  logic [CNT_W-1:0]  res_used_q, res_free_q;

  logic [PTR_W-1:0]  used, free;
  logic [AW-1:0]     addr;
  logic [LANE_W-1:0] wr_lane, cap_lane;
  logic              len_ok;

  assign used     = wptr_q - rptr_q;
  assign free     = PTR_W'(DEPTH) - used;
  assign len_ok   = (len_q != '0) && (len_q <= LEN_W'(MAX_BURST));
  assign wr_lane  = cnt_q[LANE_W-1:0];
  assign cap_lane = LANE_W'(cnt_q - LEN_W'(1));
  assign addr     = (cmd_i.use_rptr ? rptr_q[AW-1:0] : wptr_q[AW-1:0]) + AW'(cnt_q);

  assign sts_o.wr_ok    = (req_q == REQ_WRITE) && len_ok && (CW'(len_q) <= CW'(free));
  assign sts_o.rd_ok    = (req_q == REQ_READ) && len_ok && (CW'(len_q) <= CW'(used));
  assign sts_o.is_clear = (req_q == REQ_CLEAR);
  assign sts_o.last     = (cnt_q == len_q - LEN_W'(1));
  assign sts_o.out_free = !valid_q || out_ready_i;

  // item registers and byte accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_i;
      len_q   <= len_i;
      wdata_q <= wdata_i;
      rdata_q <= '0;
      cnt_q   <= '0;
      acc_q   <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + LEN_W'(1);
      if (cmd_i.set_acc) acc_q <= 1'b1;
      // first cycle of a read has nothing to capture yet
      if (cmd_i.cap && cnt_q != '0) rdata_q[8*cap_lane +: 8] <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else if (cmd_i.ptr_clr) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      if (cmd_i.wptr_adv) wptr_q <= wptr_q + PTR_W'(len_q);
      if (cmd_i.rptr_adv) rptr_q <= rptr_q + PTR_W'(len_q);
    end
  end

  // byte store, one access per cycle, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) mem_q[addr] <= wdata_q[8*wr_lane +: 8];
    rd_q <= mem_q[addr];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_acc_q   <= acc_q ? len_q : '0;
      res_rdata_q <= rdata_q;
      res_used_q  <= CNT_W'(used);
      res_free_q  <= CNT_W'(free);
    end
  end

  assign out_valid_o = valid_q;
  assign out_acc_o   = res_acc_q;
  assign out_rdata_o = res_rdata_q;
  assign out_used_o  = res_used_q;
  assign out_free_o  = res_free_q;

endmodule

// ----- sv/byte_ring_fifo_burst.sv -----
// byte fifo in a power-of-two ring store with burst write, burst read and clear
// slave channel: one request per item (tuser = request kind, tdata = length and bytes)
// master channel: one result per item (accepted count, read bytes, used and free)
// a burst of n bytes moves one byte per cycle through the single store port;
// after acceptance a write passes the decide, write and finish states, a read the
// decide, read, read-last and finish states, and a refused burst, a clear or an
// unused code the decide and finish states; the result register loads on leaving
// finish, and the block then returns to idle for the next item; one item is in work
// at a time; s_axis_tready_o is high only while the block waits for a new item
// the result sits in an output register, so the next item is accepted while it
// waits; when the receiver stalls, a finished item holds until the register drains
// bursts are all or nothing: a write beyond the free space or a read beyond the
// stored count moves no byte and reports zero
// reset empties the fifo by clearing both pointers; store contents are kept and
// are never read before being written
// depends on brfb_pkg, brfb_ctrl, brfb_dp, assert_macros.svh
`include "assert_macros.svh"
module byte_ring_fifo_burst #(
  parameter int unsigned DEPTH     = brfb_pkg::DEPTH_DEF,
  parameter int unsigned MAX_BURST = brfb_pkg::MAX_BURST_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [3:0] burst_length, [67:4] write_data, rest zero
  input  logic [brfb_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  // [1:0] req_type
  input  logic [brfb_pkg::REQ_W-1:0]        s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [3:0] accepted_count, [67:4] read_data, [78:68] used_count, [89:79] free_count,
  // rest zero
  output logic [brfb_pkg::M_TDATA_W-1:0]    m_axis_tdata_o
);
  import brfb_pkg::*;

  cmd_t              cmd;
  status_t           sts;
  logic [LEN_W-1:0]  out_acc;
  logic [DATA_W-1:0] out_rdata;
  logic [CNT_W-1:0]  out_used, out_free;

  brfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  brfb_dp #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (s_axis_tuser_i),
    .len_i       (s_axis_tdata_i[LEN_W-1:0]),
    .wdata_i     (s_axis_tdata_i[LEN_W +: DATA_W]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_acc_o   (out_acc),
    .out_rdata_o (out_rdata),
    .out_used_o  (out_used),
    .out_free_o  (out_free)
  );

  assign m_axis_tdata_o = {(M_TDATA_W - LEN_W - DATA_W - 2 * CNT_W)'(0),
                           out_free, out_used, out_rdata, out_acc};

  `ASSERT_NEXT(a_one_in_flight, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o,
    "new item taken while one is in work")
  `ASSERT_CLK(a_no_write_at_finish, !(cmd.we && cmd.out_load),
    "store write while result is loaded")
  `ASSERT_IMPL(a_acc_bound, m_axis_tvalid_o, out_acc <= LEN_W'(MAX_BURST),
    "accepted count above max burst")
  `ASSERT_IMPL(a_zero_rdata, m_axis_tvalid_o && out_acc == '0, out_rdata == '0,
    "read data not zero for an item that moved nothing")

endmodule
